// File: hw/rtl/vdm_pkg.sv
// ----------------------------------------------------------------------------
// vdm_pkg
// Shared types and constants of the vector distance unit: register indexes,
// metric and order codes, result widths and the power unit request.
// ----------------------------------------------------------------------------
package vdm_pkg;

    // result and accumulator widths
    localparam int SUM_BITS       = 64;
    localparam int DIST_BITS      = 22;
    localparam int INDEX_BITS     = 16;
    localparam int BIT_IDX_BITS   = $clog2(DIST_BITS);
    localparam int OUT_TDATA_BITS = ((DIST_BITS + INDEX_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 7;
    localparam int METRIC_BITS    = 2;
    localparam int ORDER_BITS     = 2;
    localparam int LENGTH_BITS    = 7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_METRIC = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORDER  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH = 2'd2;

    localparam logic [METRIC_BITS-1:0] METRIC_EUCLIDEAN = 2'd0;
    localparam logic [METRIC_BITS-1:0] METRIC_MANHATTAN = 2'd1;
    localparam logic [METRIC_BITS-1:0] METRIC_MINKOWSKI = 2'd2;

    // exponent codes seen by the power unit
    localparam logic [ORDER_BITS-1:0] ORDER_NONE   = 2'd0;
    localparam logic [ORDER_BITS-1:0] ORDER_LINEAR = 2'd1;
    localparam logic [ORDER_BITS-1:0] ORDER_SQUARE = 2'd2;
    localparam logic [ORDER_BITS-1:0] ORDER_CUBE   = 2'd3;

    // register values after reset
    localparam logic [METRIC_BITS-1:0] RST_METRIC = METRIC_EUCLIDEAN;
    localparam logic [ORDER_BITS-1:0]  RST_ORDER  = ORDER_SQUARE;
    localparam logic [LENGTH_BITS-1:0] RST_LENGTH = 7'd64;

    // request to the power unit
    typedef struct packed {
        logic                  valid;
        logic [ORDER_BITS-1:0] order;
    } t_pow_req;

endpackage

// File: hw/rtl/vdm_point_store.sv
// ----------------------------------------------------------------------------
// vdm_point_store
// Reference point memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vdm_point_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  logic [WIDTH-1:0]                              i_wr_data,
    input  logic                                          i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/vdm_power_unit.sv
// ----------------------------------------------------------------------------
// vdm_power_unit
// Multicycle power unit: raises an unsigned base to order 1, 2 or 3 and
// saturates the exact product to the accumulator width.
// ----------------------------------------------------------------------------
module vdm_power_unit #(
    parameter int BASE_BITS = 22
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vdm_pkg::t_pow_req             i_req,
    input  logic [BASE_BITS-1:0]          i_base,
    output logic                          o_done,
    output logic [vdm_pkg::SUM_BITS-1:0]  o_result
);

    import vdm_pkg::*;

    localparam int PROD_BITS = 3 * BASE_BITS;

    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_SQ   = 5'b00010,
        P_LO   = 5'b00100,
        P_HI   = 5'b01000,
        P_FIN  = 5'b10000
    } t_pstate;

    t_pstate                  r_state;
    t_pstate                  n_state;
    logic [BASE_BITS-1:0]     r_base;
    logic [ORDER_BITS-1:0]    r_order;
    logic [2*BASE_BITS-1:0]   r_sq;
    logic [2*BASE_BITS-1:0]   r_plo;
    logic [2*BASE_BITS-1:0]   r_phi;
    logic                     r_done;
    logic [SUM_BITS-1:0]      r_result;
    logic [PROD_BITS-1:0]     w_exact;
    logic [SUM_BITS-1:0]      w_sat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            P_IDLE:  if (i_req.valid) begin
                n_state = P_SQ;
            end
            P_SQ:    n_state = (r_order == ORDER_CUBE) ? P_LO : P_FIN;
            P_LO:    n_state = P_HI;
            P_HI:    n_state = P_FIN;
            P_FIN:   n_state = P_IDLE;
            default: n_state = P_IDLE;
        endcase
    end

    // cube is assembled from the two halves of the square
    always_comb begin
        w_exact = PROD_BITS'(r_base);
        if (r_order == ORDER_SQUARE) begin
            w_exact = PROD_BITS'(r_sq);
        end else if (r_order == ORDER_CUBE) begin
            w_exact = PROD_BITS'(r_plo) + (PROD_BITS'(r_phi) << BASE_BITS);
        end
        w_sat = (|w_exact[PROD_BITS-1:SUM_BITS]) ? '1 : w_exact[SUM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == P_FIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == P_IDLE && i_req.valid) begin
            r_base  <= i_base;
            r_order <= i_req.order;
        end
        if (r_state == P_SQ) begin
            r_sq <= r_base * r_base;
        end
        if (r_state == P_LO) begin
            r_plo <= r_sq[BASE_BITS-1:0] * r_base;
        end
        if (r_state == P_HI) begin
            r_phi <= r_sq[2*BASE_BITS-1:BASE_BITS] * r_base;
        end
        if (r_state == P_FIN) begin
            r_result <= w_sat;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: hw/rtl/vector_distance_metrics.sv
// ----------------------------------------------------------------------------
// vector_distance_metrics
// Distance from a stored reference vector to streamed candidate vectors:
// Euclidean, Manhattan or Minkowski, with a bit-by-bit root at vector end.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  s_axis    in         s_axis_tvalid/tready    tuser: action; tdata: element
//  m_axis    out        m_axis_tvalid/tready    tdata: distance, candidate idx
//  cfg       in         i_cfg_wr_en             i_cfg_index, i_cfg_data
//
//  Reference load request: one write to the point store.
//  Candidate element: store read, then power unit square (and two partial products at order 3).
//  Last element adds 22 root steps on the same power unit; the emit state then posts the result.
//  Posting waits only for the output register to drain; while a result waits to post, no request is taken.
//  Reset is synchronous, active low; the point store has no reset, load it first.
//
module vector_distance_metrics #(
    parameter int MAX_DIM      = 64,
    parameter int ELEMENT_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration writes
    input  logic                                     i_cfg_wr_en,
    input  logic [vdm_pkg::CFG_INDEX_BITS-1:0]       i_cfg_index,
    input  logic [vdm_pkg::CFG_DATA_BITS-1:0]        i_cfg_data,
    // element requests
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: element_value [ELEMENT_BITS-1:0], zero padding above
    input  logic [((ELEMENT_BITS + 7) / 8) * 8-1:0]  s_axis_tdata,
    // tuser: action [0]
    input  logic                                     s_axis_tuser,
    // results
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // tdata: distance [21:0], candidate_index [37:22], zero padding above
    output logic [vdm_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata
);

    import vdm_pkg::*;

    localparam int ADDR_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LEN_BITS  = $clog2(MAX_DIM + 1);
    localparam int EXT_BITS  = (LEN_BITS > LENGTH_BITS) ? LEN_BITS : LENGTH_BITS;
    localparam int BASE_BITS = (ELEMENT_BITS > DIST_BITS) ? ELEMENT_BITS : DIST_BITS;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_READ      = 6'b000010,
        S_TERM      = 6'b000100,
        S_ROOT_REQ  = 6'b001000,
        S_ROOT_WAIT = 6'b010000,
        S_EMIT      = 6'b100000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;

    // configuration
    logic [METRIC_BITS-1:0]    r_metric;
    logic [ORDER_BITS-1:0]     r_order;
    logic [LENGTH_BITS-1:0]    r_vec_len;

    // vector state
    logic [ADDR_BITS-1:0]      r_load_pos;
    logic [ADDR_BITS-1:0]      r_cand_pos;
    logic [SUM_BITS-1:0]       r_sum;
    logic [INDEX_BITS-1:0]     r_cand_cnt;
    logic [ELEMENT_BITS-1:0]   r_elem;
    logic [DIST_BITS-1:0]      r_root;
    logic [BIT_IDX_BITS-1:0]   r_bit;

    // output register
    logic                      r_out_valid;
    logic [DIST_BITS-1:0]      r_out_dist;
    logic [INDEX_BITS-1:0]     r_out_idx;

    logic                      w_in_accept;
    logic                      w_is_cand;
    logic                      w_cfg_hit;
    logic                      w_out_free;
    logic [EXT_BITS-1:0]       w_len_ext;
    logic [LEN_BITS-1:0]       w_len;
    logic [ORDER_BITS-1:0]     w_k;
    logic [LEN_BITS-1:0]       w_load_next;
    logic [LEN_BITS-1:0]       w_cand_next;
    logic                      w_cand_last;
    logic [ELEMENT_BITS-1:0]   w_ref;
    logic signed [ELEMENT_BITS:0] w_diff;
    logic [ELEMENT_BITS:0]     w_mag;
    logic [DIST_BITS-1:0]      w_trial;
    logic [SUM_BITS:0]         w_sum_add;
    logic [SUM_BITS-1:0]       w_sum_sat;
    t_pow_req                  w_pow_req;
    logic [BASE_BITS-1:0]      w_pow_base;
    logic                      w_pow_done;
    logic [SUM_BITS-1:0]       w_pow_result;

    assign w_in_accept = s_axis_tvalid && s_axis_tready;
    assign w_is_cand   = s_axis_tuser;
    assign w_out_free  = !r_out_valid || m_axis_tready;
    assign w_cfg_hit   = i_cfg_wr_en && (i_cfg_index == CFG_METRIC ||
                         i_cfg_index == CFG_ORDER || i_cfg_index == CFG_LENGTH);

    // clamp length into 1..MAX_DIM
    always_comb begin
        w_len_ext = EXT_BITS'(r_vec_len);
        if (r_vec_len == '0) begin
            w_len = LEN_BITS'(1);
        end else if (w_len_ext > EXT_BITS'(MAX_DIM)) begin
            w_len = LEN_BITS'(MAX_DIM);
        end else begin
            w_len = w_len_ext[LEN_BITS-1:0];
        end
    end

    // exponent and root order of the active metric; unknown metric is Euclidean
    always_comb begin
        unique case (r_metric)
            METRIC_MANHATTAN: w_k = ORDER_LINEAR;
            METRIC_MINKOWSKI: w_k = (r_order == ORDER_NONE) ? ORDER_LINEAR : r_order;
            default:          w_k = ORDER_SQUARE;
        endcase
    end

    assign w_load_next = LEN_BITS'(r_load_pos) + LEN_BITS'(1);
    assign w_cand_next = LEN_BITS'(r_cand_pos) + LEN_BITS'(1);
    assign w_cand_last = (w_cand_next >= w_len);

    // absolute difference fits ELEMENT_BITS unsigned
    assign w_diff = $signed({w_ref[ELEMENT_BITS-1], w_ref})
                  - $signed({r_elem[ELEMENT_BITS-1], r_elem});
    assign w_mag  = w_diff[ELEMENT_BITS] ? (-w_diff) : w_diff;

    assign w_trial = r_root | (DIST_BITS'(1) << r_bit);

    // saturating accumulate
    assign w_sum_add = {1'b0, r_sum} + {1'b0, w_pow_result};
    assign w_sum_sat = w_sum_add[SUM_BITS] ? '1 : w_sum_add[SUM_BITS-1:0];

    // share the power unit between term and root trial
    always_comb begin
        w_pow_req.valid = (r_state == S_READ) || (r_state == S_ROOT_REQ);
        w_pow_req.order = w_k;
        w_pow_base      = (r_state == S_READ) ? BASE_BITS'(w_mag[ELEMENT_BITS-1:0])
                                              : BASE_BITS'(w_trial);
    end

    vdm_point_store #(
        .DEPTH (MAX_DIM),
        .WIDTH (ELEMENT_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_accept && !w_is_cand),
        .i_wr_addr (r_load_pos),
        .i_wr_data (s_axis_tdata[ELEMENT_BITS-1:0]),
        .i_rd_en   (w_in_accept && w_is_cand),
        .i_rd_addr (r_cand_pos),
        .o_rd_data (w_ref)
    );

    vdm_power_unit #(
        .BASE_BITS (BASE_BITS)
    ) u_power (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_pow_req),
        .i_base   (w_pow_base),
        .o_done   (w_pow_done),
        .o_result (w_pow_result)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (w_in_accept && w_is_cand) begin
                n_state = S_READ;
            end
            S_READ:      n_state = S_TERM;
            S_TERM:      if (w_pow_done) begin
                n_state = w_cand_last ? S_ROOT_REQ : S_IDLE;
            end
            S_ROOT_REQ:  n_state = S_ROOT_WAIT;
            S_ROOT_WAIT: if (w_pow_done) begin
                n_state = (r_bit == '0) ? S_EMIT : S_ROOT_REQ;
            end
            S_EMIT:      if (w_out_free) begin
                n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_metric    <= RST_METRIC;
            r_order     <= RST_ORDER;
            r_vec_len   <= RST_LENGTH;
            r_load_pos  <= '0;
            r_cand_pos  <= '0;
            r_sum       <= '0;
            r_cand_cnt  <= '0;
            r_root      <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // drop the result once taken, hold it otherwise
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_hit) begin
                // a register write restarts both vectors; reference data stays
                unique case (i_cfg_index)
                    CFG_METRIC: r_metric  <= i_cfg_data[METRIC_BITS-1:0];
                    CFG_ORDER:  r_order   <= i_cfg_data[ORDER_BITS-1:0];
                    default:    r_vec_len <= i_cfg_data[LENGTH_BITS-1:0];
                endcase
                r_load_pos <= '0;
                r_cand_pos <= '0;
                r_sum      <= '0;
            end else begin
                priority if (r_state == S_IDLE && w_in_accept && !w_is_cand) begin
                    // reference load restarts candidate numbering
                    r_load_pos <= (w_load_next >= w_len) ? '0
                                                         : w_load_next[ADDR_BITS-1:0];
                    r_cand_pos <= '0;
                    r_sum      <= '0;
                    r_cand_cnt <= '0;
                end else if (r_state == S_TERM && w_pow_done) begin
                    r_sum <= w_sum_sat;
                    if (w_cand_last) begin
                        r_root <= '0;
                        r_bit  <= BIT_IDX_BITS'(DIST_BITS - 1);
                    end else begin
                        r_cand_pos <= w_cand_next[ADDR_BITS-1:0];
                    end
                end else if (r_state == S_ROOT_WAIT && w_pow_done) begin
                    // keep the trial bit when its power does not exceed the sum
                    if (w_pow_result <= r_sum) begin
                        r_root <= w_trial;
                    end
                    r_bit <= r_bit - BIT_IDX_BITS'(1);
                end else if (r_state == S_EMIT && w_out_free) begin
                    r_cand_cnt <= r_cand_cnt + INDEX_BITS'(1);
                    r_cand_pos <= '0;
                    r_sum      <= '0;
                end else begin
                    r_sum <= r_sum;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept && w_is_cand) begin
            r_elem <= s_axis_tdata[ELEMENT_BITS-1:0];
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_dist <= r_root;
            r_out_idx  <= r_cand_cnt;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'({r_out_idx, r_out_dist});

`ifndef SYNTHESIS
    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pow_done |-> (r_state == S_TERM || r_state == S_ROOT_WAIT))
        else $error("power unit finished with no consumer waiting");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && !w_cfg_hit) |=>
        (r_sum == '0 && r_cand_pos == '0 && r_out_valid))
        else $error("candidate state not cleared after result");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT_REQ) |-> (r_bit < BIT_IDX_BITS'(DIST_BITS)))
        else $error("root bit index out of range");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == S_EMIT))
        else $error("result posted outside of emit");
`endif

endmodule

// File: tb/tb_vector_distance_metrics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_distance_metrics
// Self-checking bench for the vector distance unit. A behavioral copy of the
// unit tracks the point store, the running power sum and the candidate count,
// and queues the distance each candidate should produce. Directed requests
// cover field extremes, every metric and order code, the clamped lengths and
// the restart rules; random phases then stream reference loads and candidate
// vectors under random configurations, with random gaps on both streams.
// ----------------------------------------------------------------------------
module tb_vector_distance_metrics;
    import vdm_pkg::*;

    localparam int IN_TDATA_BITS = 16;
    localparam int ITEM_TARGET   = 1050;
    localparam int SETTLE_CYCLES = 200;   // above the slowest request
    localparam int MAX_POINTS    = 64;

    localparam logic ACTION_LOAD      = 1'b0;
    localparam logic ACTION_CANDIDATE = 1'b1;
    // metric code with no meaning of its own, handled as euclidean
    localparam logic [METRIC_BITS-1:0] METRIC_CODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_BITS-1:0]  distance;
        logic [INDEX_BITS-1:0] index;
    } t_distance_result;

    // DUT ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;   // element_value [15:0]
    logic                      s_axis_tuser = 1'b0; // action [0]
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;        // distance [21:0], candidate_index [37:22]

    // shadow of the unit
    logic [15:0]           point_store [MAX_POINTS];
    int                    load_pos = 0;
    int                    cand_pos = 0;
    logic [SUM_BITS-1:0]   power_sum = '0;
    logic [INDEX_BITS-1:0] cand_count = '0;
    logic [METRIC_BITS-1:0] cfg_metric = RST_METRIC;
    logic [ORDER_BITS-1:0]  cfg_order  = RST_ORDER;
    logic [LENGTH_BITS-1:0] cfg_length = RST_LENGTH;

    t_distance_result expected_distances[$];

    bit throttle_on = 1'b1;
    int items_sent = 0;
    int distances_checked = 0;
    int registers_written = 0;
    int error_count = 0;
    int results_by_order[4] = '{0, 0, 0, 0};

    vector_distance_metrics #(
        .MAX_DIM      (64),
        .ELEMENT_BITS (16)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow model
    // ------------------------------------------------------------------
    function automatic int effective_order();
        if (cfg_metric == METRIC_MANHATTAN) begin
            return 1;
        end
        if (cfg_metric == METRIC_MINKOWSKI) begin
            return (cfg_order == ORDER_NONE) ? 1 : int'(cfg_order);
        end
        return 2;
    endfunction

    function automatic int effective_length();
        if (cfg_length == 0) begin
            return 1;
        end
        if (cfg_length > MAX_POINTS) begin
            return MAX_POINTS;
        end
        return int'(cfg_length);
    endfunction

    // base^k, clamped to the top of the 64-bit range
    function automatic logic [63:0] power_saturated(logic [63:0] base, int k);
        logic [127:0] acc;
        acc = 128'd1;
        for (int i = 0; i < k; i++) begin
            acc = acc * base;
            if (acc[127:64] != 0) begin
                return '1;
            end
        end
        return acc[63:0];
    endfunction

    // floor k-th root, one bit per step from the top of the distance field
    function automatic logic [DIST_BITS-1:0] integer_root(logic [63:0] sum, int k);
        logic [DIST_BITS-1:0] r;
        logic [DIST_BITS-1:0] t;
        r = '0;
        for (int b = DIST_BITS - 1; b >= 0; b--) begin
            t = r | (DIST_BITS'(1) << b);
            if (power_saturated(64'(t), k) <= sum) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic void update_distance_model(logic action, logic [15:0] value);
        int               len;
        int               k;
        int               p;
        shortint          ref_s;
        shortint          val_s;
        longint           diff;
        logic [63:0]      term;
        logic [64:0]      wide;
        t_distance_result want;
        len = effective_length();
        k   = effective_order();
        if (action == ACTION_LOAD) begin
            p = load_pos;
            point_store[p] = value;
            load_pos   = (p + 1 >= len) ? 0 : p + 1;
            cand_pos   = 0;
            power_sum  = '0;
            cand_count = '0;
        end else begin
            p     = cand_pos;
            ref_s = point_store[p];
            val_s = value;
            diff  = longint'(ref_s) - longint'(val_s);
            if (diff < 0) begin
                diff = -diff;
            end
            term = power_saturated(64'(diff), k);
            wide = {1'b0, power_sum} + {1'b0, term};
            power_sum = wide[64] ? '1 : wide[63:0];
            if (p + 1 >= len) begin
                want.distance = integer_root(power_sum, k);
                want.index    = cand_count;
                expected_distances.push_back(want);
                results_by_order[k]++;
                cand_count = cand_count + 1'b1;
                cand_pos   = 0;
                power_sum  = '0;
            end else begin
                cand_pos = p + 1;
            end
        end
    endfunction

    function automatic void apply_register_write(logic [CFG_INDEX_BITS-1:0] index,
                                                 logic [CFG_DATA_BITS-1:0] value);
        case (index)
            CFG_METRIC: cfg_metric = value[METRIC_BITS-1:0];
            CFG_ORDER:  cfg_order  = value[ORDER_BITS-1:0];
            CFG_LENGTH: cfg_length = value[LENGTH_BITS-1:0];
            default: return;
        endcase
        load_pos  = 0;
        cand_pos  = 0;
        power_sum = '0;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the in-order checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        m_axis_tready <= !throttle_on || ($urandom_range(0, 99) >= 24);
    end

    task automatic report_mismatch(string what, longint want, longint got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_distances
        t_distance_result want;
        t_distance_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.distance = m_axis_tdata[DIST_BITS-1:0];
            got.index    = m_axis_tdata[DIST_BITS +: INDEX_BITS];
            if (expected_distances.size() == 0) begin
                report_mismatch("result with none pending, distance", -1, got.distance);
            end else begin
                want = expected_distances.pop_front();
                if (got.distance != want.distance) begin
                    report_mismatch("distance", want.distance, got.distance);
                end
                if (got.index != want.index) begin
                    report_mismatch("candidate_index", want.index, got.index);
                end
                distances_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Leave valid high after acceptance so back-to-back requests need only one
    // assignment per edge; drop it only when a gap is taken or the sender waits for results.
    task automatic send_element(logic action, logic [15:0] value);
        if (throttle_on) begin
            while ($urandom_range(0, 99) < 24) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        update_distance_model(action, value);
        items_sent++;
    endtask

    // Hold the sender until every pending distance has come back, then let
    // any result-less request still inside the unit finish.
    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_distances.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // call only after wait_results_drained
    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        apply_register_write(index, value);
        registers_written++;
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_candidate2(logic [15:0] first, logic [15:0] second);
        send_element(ACTION_CANDIDATE, first);
        send_element(ACTION_CANDIDATE, second);
    endtask

    // Mix extremes, exact matches and near misses with fully random elements.
    function automatic logic [15:0] pick_element(logic [15:0] near);
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return near;
            3, 4:    return near + 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return 7'd0;
            1:       return 7'($urandom_range(65, 127));
            2, 3:    return 7'($urandom_range(9, 64));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Fill the whole point store at the reset length, so no later candidate
    // reads an unwritten entry, and measure one candidate at reset settings.
    task automatic test_reset_settings();
        for (int i = 0; i < MAX_POINTS; i++) begin
            send_element(ACTION_LOAD, (i == 0) ? 16'h7FFF :
                                      (i == 1) ? 16'h8000 : 16'($urandom_range(0, 65535)));
        end
        for (int i = 0; i < MAX_POINTS; i++) begin
            send_element(ACTION_CANDIDATE, pick_element(point_store[i]));
        end
    endtask

    // Two-element vectors with the largest, zero and intermediate differences, across
    // every metric and order code.
    task automatic test_metrics_and_orders();
        wait_results_drained();
        write_register(CFG_LENGTH, 7'd2);
        send_element(ACTION_LOAD, 16'h7FFF);
        send_element(ACTION_LOAD, 16'h8000);
        send_candidate2(16'h8000, 16'h7FFF);
        send_candidate2(16'h7FFF, 16'h8000);
        wait_results_drained();
        write_register(CFG_METRIC, CFG_DATA_BITS'(METRIC_MANHATTAN));
        send_candidate2(16'h8000, 16'h7FFF);
        wait_results_drained();
        write_register(CFG_METRIC, CFG_DATA_BITS'(METRIC_MINKOWSKI));
        write_register(CFG_ORDER, CFG_DATA_BITS'(ORDER_CUBE));
        send_candidate2(16'h8000, 16'h7FFF);
        send_candidate2(16'h7F00, 16'h8001);
        wait_results_drained();
        write_register(CFG_ORDER, CFG_DATA_BITS'(ORDER_LINEAR));
        send_candidate2(16'h0000, 16'hFFFF);
        wait_results_drained();
        // order zero falls back to order one
        write_register(CFG_ORDER, CFG_DATA_BITS'(ORDER_NONE));
        send_candidate2(16'h8000, 16'h0001);
        wait_results_drained();
        write_register(CFG_ORDER, CFG_DATA_BITS'(ORDER_SQUARE));
        send_candidate2(16'h1234, 16'hEDCB);
        wait_results_drained();
        // unused metric code acts as euclidean
        write_register(CFG_METRIC, CFG_DATA_BITS'(METRIC_CODE_UNUSED));
        send_candidate2(16'h8000, 16'h7FFF);
    endtask

    // A reference load inside a candidate restarts it and the index count;
    // a register write inside a candidate restarts it but keeps the count.
    task automatic test_restarts();
        send_element(ACTION_CANDIDATE, 16'h0100);
        send_element(ACTION_LOAD, 16'h0200);
        send_candidate2(16'h0000, 16'h0000);
        send_element(ACTION_CANDIDATE, 16'h4000);
        wait_results_drained();
        write_register(CFG_LENGTH, 7'd2);
        send_candidate2(16'hFF00, 16'h00FF);
    endtask

    // Length zero acts as one; lengths past the store act as the store size.
    task automatic test_length_clamps();
        wait_results_drained();
        write_register(CFG_METRIC, CFG_DATA_BITS'(METRIC_EUCLIDEAN));
        write_register(CFG_LENGTH, 7'd0);
        send_element(ACTION_CANDIDATE, 16'h8000);
        send_element(ACTION_CANDIDATE, 16'h7FFF);
        wait_results_drained();
        write_register(CFG_LENGTH, 7'd127);
        for (int i = 0; i < MAX_POINTS; i++) begin
            send_element(ACTION_CANDIDATE, pick_element(point_store[i]));
        end
    endtask

    // One random phase: new settings, maybe a new reference, then candidates
    // with a little noise (stray loads, stray candidates, cut-short vectors).
    task automatic run_random_phase();
        int len;
        int vectors;
        wait_results_drained();
        if ($urandom_range(0, 3) != 0) begin
            write_register(CFG_METRIC, CFG_DATA_BITS'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 2) != 0) begin
            write_register(CFG_ORDER, CFG_DATA_BITS'($urandom_range(0, 3)));
        end
        if ($urandom_range(0, 2) != 0) begin
            write_register(CFG_LENGTH, pick_length());
        end
        len = effective_length();
        if ($urandom_range(0, 2) == 0) begin
            for (int i = 0; i < len; i++) begin
                send_element(ACTION_LOAD, 16'($urandom_range(0, 65535)));
            end
        end
        vectors = (len > 16) ? $urandom_range(1, 2) : $urandom_range(2, 8);
        for (int v = 0; v < vectors; v++) begin
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(0, 39) == 0) begin
                    send_element(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
                end else if ($urandom_range(0, 79) == 0) begin
                    break;
                end else begin
                    send_element(ACTION_CANDIDATE, pick_element(point_store[j]));
                end
            end
        end
    endtask

    // no gaps on either stream for a stretch
    task automatic test_back_to_back();
        int stop_at;
        stop_at = items_sent + 200;
        throttle_on = 1'b0;
        while (items_sent < stop_at) begin
            run_random_phase();
        end
        throttle_on = 1'b1;
    endtask

    task automatic test_random_phases();
        while (items_sent < ITEM_TARGET) begin
            run_random_phase();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_metrics_and_orders();
        test_restarts();
        test_length_clamps();
        test_back_to_back();
        test_random_phases();

        wait_results_drained();
        $display("Run covered %0d element requests, %0d distances, %0d register writes",
                 items_sent, distances_checked, registers_written);
        $display("Distances per root order 1/2/3: %0d/%0d/%0d, mismatches: %0d",
                 results_by_order[1], results_by_order[2], results_by_order[3], error_count);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin
        #20_000_000;
        $display("Timeout with %0d distances still pending", expected_distances.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/vdm_pkg.sv
hw/rtl/vdm_point_store.sv
hw/rtl/vdm_power_unit.sv
hw/rtl/vector_distance_metrics.sv
tb/tb_vector_distance_metrics.sv
